// ===== rtl/core/eight_bit_cpu_execute_unit_top_assert.svh =====
// assertion macros for the execute unit, clocked on clk_i, quiet while rst_ni is low
`ifndef EIGHT_BIT_CPU_EXECUTE_UNIT_TOP_ASSERT_SVH
`define EIGHT_BIT_CPU_EXECUTE_UNIT_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("execute unit assertion failed");
`define ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("execute unit forbidden condition");
`else
`define ASSERT_CLK(label, prop)
`define ASSERT_NEVER(label, expr)
`endif

`endif

// ===== rtl/core/cpu8_exu_pkg.sv =====
`default_nettype none

package cpu8_exu_pkg;

  // instruction select, dense numbering
  typedef enum logic [5:0] {
    KIND_LDA   = 6'd0,
    KIND_LDX   = 6'd1,
    KIND_LDY   = 6'd2,
    KIND_STA   = 6'd3,
    KIND_STX   = 6'd4,
    KIND_STY   = 6'd5,
    KIND_ADC   = 6'd6,
    KIND_INC   = 6'd7,
    KIND_INX   = 6'd8,
    KIND_INY   = 6'd9,
    KIND_DEC   = 6'd10,
    KIND_DEX   = 6'd11,
    KIND_DEY   = 6'd12,
    KIND_AND   = 6'd13,
    KIND_EOR   = 6'd14,
    KIND_ORA   = 6'd15,
    KIND_JMP   = 6'd16,
    KIND_BCC   = 6'd17,
    KIND_BCS   = 6'd18,
    KIND_BEQ   = 6'd19,
    KIND_BMI   = 6'd20,
    KIND_BNE   = 6'd21,
    KIND_BPL   = 6'd22,
    KIND_BVC   = 6'd23,
    KIND_BVS   = 6'd24,
    KIND_CMP   = 6'd25,
    KIND_CPX   = 6'd26,
    KIND_CPY   = 6'd27,
    KIND_BIT   = 6'd28,
    KIND_ASL_A = 6'd29,
    KIND_ASL_M = 6'd30,
    KIND_TAX   = 6'd31,
    KIND_TAY   = 6'd32,
    KIND_TXA   = 6'd33,
    KIND_TYA   = 6'd34,
    KIND_TSX   = 6'd35,
    KIND_TXS   = 6'd36,
    KIND_PHA   = 6'd37,
    KIND_PHP   = 6'd38,
    KIND_PLA   = 6'd39,
    KIND_PLP   = 6'd40,
    KIND_JSR   = 6'd41,
    KIND_RTI   = 6'd42,
    KIND_RTS   = 6'd43,
    KIND_CLC   = 6'd44,
    KIND_CLD   = 6'd45,
    KIND_CLI   = 6'd46,
    KIND_CLV   = 6'd47,
    KIND_SEC   = 6'd48,
    KIND_SED   = 6'd49,
    KIND_SEI   = 6'd50,
    KIND_NOP   = 6'd51,
    KIND_BRK   = 6'd52
  } kind_e;

  // status bit positions
  localparam int FlagC   = 0;
  localparam int FlagZ   = 1;
  localparam int FlagI   = 2;
  localparam int FlagD   = 3;
  localparam int FlagB   = 4;
  localparam int FlagOne = 5;
  localparam int FlagV   = 6;
  localparam int FlagN   = 7;

  localparam logic [7:0] SpReset     = 8'hFD;
  localparam logic [7:0] StatusReset = 8'h24;

  // stack page split in banks so up to three neighboring bytes move per cycle
  localparam int NumBanks   = 4;
  localparam int BankSelW   = $clog2(NumBanks);
  localparam int BankDepth  = 256 / NumBanks;
  localparam int BankAddrW  = $clog2(BankDepth);
  localparam int MaxStackOp = 3;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] sp;
    logic [7:0] p;
  } cpu_state_t;

  // push i goes to address sp - i
  typedef struct packed {
    logic [MaxStackOp-1:0]       en;
    logic [MaxStackOp-1:0][7:0]  data;
  } push_req_t;

endpackage

`default_nettype wire

// ===== rtl/core/cpu8_exu_ram.sv =====
`default_nettype none

module cpu8_exu_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/core/cpu8_exu_alu.sv =====
`default_nettype none

module cpu8_exu_alu (
  input  wire cpu8_exu_pkg::cpu_state_t                        st_i,
  input  wire logic [5:0]                                      kind_i,
  input  wire logic [7:0]                                      operand_i,
  input  wire logic [7:0]                                      operand_high_i,
  input  wire logic [15:0]                                     next_pc_i,
  input  wire logic [cpu8_exu_pkg::MaxStackOp-1:0][7:0]        pull_i,
  output cpu8_exu_pkg::cpu_state_t                             st_o,
  output logic [15:0]                                          pc_o,
  output logic                                                 mem_write_o,
  output logic [7:0]                                           mem_write_data_o,
  output cpu8_exu_pkg::push_req_t                              push_o
);

  function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
    logic [7:0] r;
    r = p;
    r[cpu8_exu_pkg::FlagN] = v[7];
    r[cpu8_exu_pkg::FlagZ] = (v == 8'd0);
    return r;
  endfunction

  function automatic logic [7:0] compare(input logic [7:0] p, input logic [7:0] reg_v,
                                         input logic [7:0] m);
    logic [8:0] diff;
    logic [7:0] r;
    diff = {1'b0, reg_v} - {1'b0, m};
    r = set_nz(p, diff[7:0]);
    r[cpu8_exu_pkg::FlagC] = ~diff[8];
    return r;
  endfunction

  function automatic logic [7:0] pulled_status(input logic [7:0] v);
    logic [7:0] r;
    r = v;
    r[cpu8_exu_pkg::FlagB]   = 1'b0;
    r[cpu8_exu_pkg::FlagOne] = 1'b1;
    return r;
  endfunction

  logic [8:0]  adc_sum;
  logic [7:0]  adc_res;
  logic [15:0] br_target;
  logic [15:0] jmp_target;
  logic [15:0] ret_addr;
  logic [7:0]  push_status;
  logic [7:0]  inc_m;
  logic [7:0]  dec_m;
  logic [7:0]  asl_m;

  assign adc_sum     = {1'b0, st_i.a} + {1'b0, operand_i} + {8'd0, st_i.p[cpu8_exu_pkg::FlagC]};
  assign adc_res     = adc_sum[7:0];
  assign br_target   = next_pc_i + {{8{operand_i[7]}}, operand_i};
  assign jmp_target  = {operand_high_i, operand_i};
  assign ret_addr    = next_pc_i - 16'd1;
  assign push_status = st_i.p | 8'h30;
  assign inc_m       = operand_i + 8'd1;
  assign dec_m       = operand_i - 8'd1;
  assign asl_m       = {operand_i[6:0], 1'b0};

  always_comb begin
    st_o             = st_i;
    pc_o             = next_pc_i;
    mem_write_o      = 1'b0;
    mem_write_data_o = 8'd0;
    push_o           = '0;
    case (cpu8_exu_pkg::kind_e'(kind_i))
      cpu8_exu_pkg::KIND_LDA: begin
        st_o.a = operand_i;
        st_o.p = set_nz(st_i.p, operand_i);
      end
      cpu8_exu_pkg::KIND_LDX: begin
        st_o.x = operand_i;
        st_o.p = set_nz(st_i.p, operand_i);
      end
      cpu8_exu_pkg::KIND_LDY: begin
        st_o.y = operand_i;
        st_o.p = set_nz(st_i.p, operand_i);
      end
      cpu8_exu_pkg::KIND_STA: begin
        mem_write_o      = 1'b1;
        mem_write_data_o = st_i.a;
      end
      cpu8_exu_pkg::KIND_STX: begin
        mem_write_o      = 1'b1;
        mem_write_data_o = st_i.x;
      end
      cpu8_exu_pkg::KIND_STY: begin
        mem_write_o      = 1'b1;
        mem_write_data_o = st_i.y;
      end
      cpu8_exu_pkg::KIND_ADC: begin
        st_o.a = adc_res;
        st_o.p = set_nz(st_i.p, adc_res);
        st_o.p[cpu8_exu_pkg::FlagC] = adc_sum[8];
        // overflow when both addends agree in sign and the sum does not
        st_o.p[cpu8_exu_pkg::FlagV] = ~(st_i.a[7] ^ operand_i[7]) & (st_i.a[7] ^ adc_res[7]);
      end
      cpu8_exu_pkg::KIND_INC: begin
        mem_write_o      = 1'b1;
        mem_write_data_o = inc_m;
        st_o.p           = set_nz(st_i.p, inc_m);
      end
      cpu8_exu_pkg::KIND_INX: begin
        st_o.x = st_i.x + 8'd1;
        st_o.p = set_nz(st_i.p, st_i.x + 8'd1);
      end
      cpu8_exu_pkg::KIND_INY: begin
        st_o.y = st_i.y + 8'd1;
        st_o.p = set_nz(st_i.p, st_i.y + 8'd1);
      end
      cpu8_exu_pkg::KIND_DEC: begin
        mem_write_o      = 1'b1;
        mem_write_data_o = dec_m;
        st_o.p           = set_nz(st_i.p, dec_m);
      end
      cpu8_exu_pkg::KIND_DEX: begin
        st_o.x = st_i.x - 8'd1;
        st_o.p = set_nz(st_i.p, st_i.x - 8'd1);
      end
      cpu8_exu_pkg::KIND_DEY: begin
        st_o.y = st_i.y - 8'd1;
        st_o.p = set_nz(st_i.p, st_i.y - 8'd1);
      end
      cpu8_exu_pkg::KIND_AND: begin
        st_o.a = st_i.a & operand_i;
        st_o.p = set_nz(st_i.p, st_i.a & operand_i);
      end
      cpu8_exu_pkg::KIND_EOR: begin
        st_o.a = st_i.a ^ operand_i;
        st_o.p = set_nz(st_i.p, st_i.a ^ operand_i);
      end
      cpu8_exu_pkg::KIND_ORA: begin
        st_o.a = st_i.a | operand_i;
        st_o.p = set_nz(st_i.p, st_i.a | operand_i);
      end
      cpu8_exu_pkg::KIND_JMP: pc_o = jmp_target;
      cpu8_exu_pkg::KIND_BCC: if (!st_i.p[cpu8_exu_pkg::FlagC]) pc_o = br_target;
      cpu8_exu_pkg::KIND_BCS: if (st_i.p[cpu8_exu_pkg::FlagC]) pc_o = br_target;
      cpu8_exu_pkg::KIND_BEQ: if (st_i.p[cpu8_exu_pkg::FlagZ]) pc_o = br_target;
      cpu8_exu_pkg::KIND_BMI: if (st_i.p[cpu8_exu_pkg::FlagN]) pc_o = br_target;
      cpu8_exu_pkg::KIND_BNE: if (!st_i.p[cpu8_exu_pkg::FlagZ]) pc_o = br_target;
      cpu8_exu_pkg::KIND_BPL: if (!st_i.p[cpu8_exu_pkg::FlagN]) pc_o = br_target;
      cpu8_exu_pkg::KIND_BVC: if (!st_i.p[cpu8_exu_pkg::FlagV]) pc_o = br_target;
      cpu8_exu_pkg::KIND_BVS: if (st_i.p[cpu8_exu_pkg::FlagV]) pc_o = br_target;
      cpu8_exu_pkg::KIND_CMP: st_o.p = compare(st_i.p, st_i.a, operand_i);
      cpu8_exu_pkg::KIND_CPX: st_o.p = compare(st_i.p, st_i.x, operand_i);
      cpu8_exu_pkg::KIND_CPY: st_o.p = compare(st_i.p, st_i.y, operand_i);
      cpu8_exu_pkg::KIND_BIT: begin
        st_o.p[cpu8_exu_pkg::FlagZ] = ((st_i.a & operand_i) == 8'd0);
        st_o.p[cpu8_exu_pkg::FlagN] = operand_i[7];
        st_o.p[cpu8_exu_pkg::FlagV] = operand_i[6];
      end
      cpu8_exu_pkg::KIND_ASL_A: begin
        st_o.a = {st_i.a[6:0], 1'b0};
        st_o.p = set_nz(st_i.p, {st_i.a[6:0], 1'b0});
        st_o.p[cpu8_exu_pkg::FlagC] = st_i.a[7];
      end
      cpu8_exu_pkg::KIND_ASL_M: begin
        mem_write_o      = 1'b1;
        mem_write_data_o = asl_m;
        st_o.p           = set_nz(st_i.p, asl_m);
        st_o.p[cpu8_exu_pkg::FlagC] = operand_i[7];
      end
      cpu8_exu_pkg::KIND_TAX: begin
        st_o.x = st_i.a;
        st_o.p = set_nz(st_i.p, st_i.a);
      end
      cpu8_exu_pkg::KIND_TAY: begin
        st_o.y = st_i.a;
        st_o.p = set_nz(st_i.p, st_i.a);
      end
      cpu8_exu_pkg::KIND_TXA: begin
        st_o.a = st_i.x;
        st_o.p = set_nz(st_i.p, st_i.x);
      end
      cpu8_exu_pkg::KIND_TYA: begin
        st_o.a = st_i.y;
        st_o.p = set_nz(st_i.p, st_i.y);
      end
      cpu8_exu_pkg::KIND_TSX: begin
        st_o.x = st_i.sp;
        st_o.p = set_nz(st_i.p, st_i.sp);
      end
      cpu8_exu_pkg::KIND_TXS: st_o.sp = st_i.x;
      cpu8_exu_pkg::KIND_PHA: begin
        push_o.en[0]   = 1'b1;
        push_o.data[0] = st_i.a;
        st_o.sp        = st_i.sp - 8'd1;
      end
      cpu8_exu_pkg::KIND_PHP: begin
        push_o.en[0]   = 1'b1;
        push_o.data[0] = push_status;
        st_o.sp        = st_i.sp - 8'd1;
      end
      cpu8_exu_pkg::KIND_PLA: begin
        st_o.a  = pull_i[0];
        st_o.p  = set_nz(st_i.p, pull_i[0]);
        st_o.sp = st_i.sp + 8'd1;
      end
      cpu8_exu_pkg::KIND_PLP: begin
        st_o.p  = pulled_status(pull_i[0]);
        st_o.sp = st_i.sp + 8'd1;
      end
      cpu8_exu_pkg::KIND_JSR: begin
        // return address minus one, high byte pushed first
        push_o.en[1:0] = 2'b11;
        push_o.data[0] = ret_addr[15:8];
        push_o.data[1] = ret_addr[7:0];
        st_o.sp        = st_i.sp - 8'd2;
        pc_o           = jmp_target;
      end
      cpu8_exu_pkg::KIND_RTI: begin
        st_o.p  = pulled_status(pull_i[0]);
        st_o.sp = st_i.sp + 8'd3;
        pc_o    = {pull_i[2], pull_i[1]};
      end
      cpu8_exu_pkg::KIND_RTS: begin
        st_o.sp = st_i.sp + 8'd2;
        pc_o    = {pull_i[1], pull_i[0]} + 16'd1;
      end
      cpu8_exu_pkg::KIND_CLC: st_o.p[cpu8_exu_pkg::FlagC] = 1'b0;
      cpu8_exu_pkg::KIND_CLD: st_o.p[cpu8_exu_pkg::FlagD] = 1'b0;
      cpu8_exu_pkg::KIND_CLI: st_o.p[cpu8_exu_pkg::FlagI] = 1'b0;
      cpu8_exu_pkg::KIND_CLV: st_o.p[cpu8_exu_pkg::FlagV] = 1'b0;
      cpu8_exu_pkg::KIND_SEC: st_o.p[cpu8_exu_pkg::FlagC] = 1'b1;
      cpu8_exu_pkg::KIND_SED: st_o.p[cpu8_exu_pkg::FlagD] = 1'b1;
      cpu8_exu_pkg::KIND_SEI: st_o.p[cpu8_exu_pkg::FlagI] = 1'b1;
      cpu8_exu_pkg::KIND_NOP: st_o = st_i;
      cpu8_exu_pkg::KIND_BRK: begin
        // vector fetch lives outside, pc stays at next_pc
        push_o.en      = 3'b111;
        push_o.data[0] = next_pc_i[15:8];
        push_o.data[1] = next_pc_i[7:0];
        push_o.data[2] = push_status;
        st_o.sp        = st_i.sp - 8'd3;
        st_o.p[cpu8_exu_pkg::FlagI] = 1'b1;
      end
      default: st_o = st_i;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/eight_bit_cpu_execute_unit_top.sv =====
`default_nettype none
`include "eight_bit_cpu_execute_unit_top_assert.svh"

// channel | dir | tdata fields, lowest bit up                             | tuser
// --------+-----+---------------------------------------------------------+----------
// s_axis  | in  | operand, operand_high, next_pc (32 bits)                | kind[5:0]
// m_axis  | out | pc_out, mem_write_data, acc, x, y, sp, status (64 bits) | mem_write
//
// one instruction per cycle while m_axis does not stall; an accepted transaction waits in the
// input register until the result register is free, then its result is registered and offered
// the stack page is four 64x8 banks with registered read, addressed from the next
// stack pointer, with the last write forwarded
// reset clears A, X, Y, sets sp to 0xfd and status to 0x24; stack contents are undefined
// s_axis_tready drops only when a stalled result and a waiting transaction fill both registers

module eight_bit_cpu_execute_unit_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // operand, operand_high, next_pc
  input  wire logic [5:0]  s_axis_tuser,   // kind

  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,   // pc_out, mem_write_data, acc, x, y, sp, status
  output logic             m_axis_tuser    // mem_write
);

  localparam int NB = cpu8_exu_pkg::NumBanks;
  localparam int AW = cpu8_exu_pkg::BankAddrW;
  localparam int SW = cpu8_exu_pkg::BankSelW;
  localparam int NS = cpu8_exu_pkg::MaxStackOp;

  // input register
  logic        in_valid_q;
  logic [5:0]  kind_q;
  logic [7:0]  operand_q;
  logic [7:0]  operand_high_q;
  logic [15:0] next_pc_q;

  // architectural state
  cpu8_exu_pkg::cpu_state_t st_q;
  cpu8_exu_pkg::cpu_state_t st_d;

  // result register
  logic        out_valid_q;
  logic [63:0] out_data_q;
  logic        out_wr_q;

  logic        exec_fire;
  logic        in_fire;
  logic [15:0] pc_d;
  logic        mem_write_d;
  logic [7:0]  mem_write_data_d;

  cpu8_exu_pkg::push_req_t push;
  logic [NS-1:0][7:0]      pull;

  // stack banks
  logic [NB-1:0]           bank_we;
  logic [NB-1:0][AW-1:0]   bank_waddr;
  logic [NB-1:0][7:0]      bank_wdata;
  logic [NB-1:0][AW-1:0]   bank_raddr;
  logic [NB-1:0][7:0]      bank_rdata;
  logic [NB-1:0][7:0]      bank_fwd;
  logic [NB-1:0]           wr_en_q;
  logic [NB-1:0][AW-1:0]   wr_addr_q;
  logic [NB-1:0][7:0]      wr_data_q;
  logic [NB-1:0][AW-1:0]   rd_addr_q;

  logic [7:0] sp_rd;
  logic [7:0] rd_base;

  // the instruction in the input register runs when the result slot is free
  assign exec_fire     = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | exec_fire;
  assign in_fire       = s_axis_tvalid & s_axis_tready;

  cpu8_exu_alu u_alu (
    .st_i             (st_q),
    .kind_i           (kind_q),
    .operand_i        (operand_q),
    .operand_high_i   (operand_high_q),
    .next_pc_i        (next_pc_q),
    .pull_i           (pull),
    .st_o             (st_d),
    .pc_o             (pc_d),
    .mem_write_o      (mem_write_d),
    .mem_write_data_o (mem_write_data_d),
    .push_o           (push)
  );

  // pushes land at sp, sp-1, sp-2: always three different banks
  always_comb begin
    logic [7:0] pa;
    bank_we    = '0;
    bank_waddr = '0;
    bank_wdata = '0;
    for (int i = 0; i < NS; i++) begin
      pa = st_q.sp - 8'(i);
      if (exec_fire && push.en[i]) begin
        bank_we[pa[SW-1:0]]    = 1'b1;
        bank_waddr[pa[SW-1:0]] = pa[7:SW];
        bank_wdata[pa[SW-1:0]] = push.data[i];
      end
    end
  end

  // read the four bytes above the stack pointer the next instruction will see
  assign sp_rd   = exec_fire ? st_d.sp : st_q.sp;
  assign rd_base = sp_rd + 8'd1;

  for (genvar b = 0; b < NB; b++) begin : g_bank
    assign bank_raddr[b] = (rd_base[SW-1:0] <= SW'(b)) ? rd_base[7:SW]
                                                       : rd_base[7:SW] + AW'(1);

    cpu8_exu_ram #(
      .Width (8),
      .Depth (cpu8_exu_pkg::BankDepth)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (bank_we[b]),
      .waddr_i (bank_waddr[b]),
      .wdata_i (bank_wdata[b]),
      .raddr_i (bank_raddr[b]),
      .rdata_o (bank_rdata[b])
    );

    // a write on the same edge as the read is not in the read data yet
    assign bank_fwd[b] = (wr_en_q[b] && (wr_addr_q[b] == rd_addr_q[b])) ? wr_data_q[b]
                                                                       : bank_rdata[b];
  end

  // pull k reads sp+1+k
  always_comb begin
    logic [7:0] pa;
    for (int k = 0; k < NS; k++) begin
      pa      = st_q.sp + 8'(k + 1);
      pull[k] = bank_fwd[pa[SW-1:0]];
    end
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      wr_en_q     <= '0;
      st_q.a      <= 8'd0;
      st_q.x      <= 8'd0;
      st_q.y      <= 8'd0;
      st_q.sp     <= cpu8_exu_pkg::SpReset;
      st_q.p      <= cpu8_exu_pkg::StatusReset;
    end else begin
      wr_en_q <= bank_we;
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (exec_fire) begin
        out_valid_q <= 1'b1;
        st_q        <= st_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    wr_addr_q <= bank_waddr;
    wr_data_q <= bank_wdata;
    rd_addr_q <= bank_raddr;
    if (in_fire) begin
      kind_q         <= s_axis_tuser;
      operand_q      <= s_axis_tdata[7:0];
      operand_high_q <= s_axis_tdata[15:8];
      next_pc_q      <= s_axis_tdata[31:16];
    end
    if (exec_fire) begin
      out_wr_q   <= mem_write_d;
      out_data_q <= {st_d.p, st_d.sp, st_d.y, st_d.x, st_d.a, mem_write_data_d, pc_d};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_wr_q;

  // a single-byte push moves the stack pointer down by one
  `ASSERT_CLK(a_pha_sp, exec_fire && (kind_q == cpu8_exu_pkg::KIND_PHA) |=> st_q.sp == $past(st_q.sp) - 8'd1)
  // an executed instruction always leaves a result behind
  `ASSERT_CLK(a_exec_result, exec_fire |=> m_axis_tvalid)
  // input side only blocks when both registers are full and the output stalls
  `ASSERT_CLK(a_ready_low, !s_axis_tready |-> in_valid_q && out_valid_q && !m_axis_tready)
  // status bit five always reads one and B never sticks in the register
  `ASSERT_NEVER(a_status_bits, m_axis_tvalid && (!m_axis_tdata[61] || m_axis_tdata[60]))
  // no store data without a store
  `ASSERT_NEVER(a_wdata_zero, m_axis_tvalid && !m_axis_tuser && (m_axis_tdata[23:16] != 8'd0))

endmodule

`default_nettype wire
